// ===== sv/ffba_pkg.sv =====
// Shared constants, types and codes of the first-fit block allocator.
`timescale 1ns / 1ps
package ffba_pkg;

   // Table and heap geometry.
   localparam int MAX_BLOCKS   = 64;
   localparam int ALIGN_BYTES  = 64;
   localparam int HEADER_BYTES = 24;

   // Field widths.
   localparam int ADDR_W = 48;
   localparam int SIZE_W = 32;
   localparam int STAT_W = 2;
   localparam int IDX_W  = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
   localparam int CNT_W  = $clog2(MAX_BLOCKS + 1);
   localparam int INC_W  = SIZE_W + 1;
   localparam int NB_W   = ADDR_W + 2;

   // Configuration register indexes.
   localparam int CSR_IDX_W = 1;
   localparam logic [CSR_IDX_W-1:0] CSR_HEAP_BASE  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_HEAP_LIMIT = 1'b1;

   // Request actions.
   localparam logic ACT_ALLOC = 1'b0;
   localparam logic ACT_FREE  = 1'b1;

   // Response status codes.
   typedef enum logic [STAT_W-1:0] {
      STATUS_OK      = 2'd0,
      STATUS_NOMEM   = 2'd1,
      STATUS_DOUBLE  = 2'd2,
      STATUS_UNKNOWN = 2'd3
   } status_type;

   // One entry of the block table.
   typedef struct packed {
      logic [ADDR_W-1:0] start;
      logic [SIZE_W-1:0] size;
      logic              free;
   } entry_type;

   // Sequencer states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_HIT,
      ST_GROW,
      ST_COMMIT,
      ST_RESP
   } state_type;

endpackage

// ===== sv/ffba_req_if.sv =====
// Request channel of the allocator: action, size and address to free.
`timescale 1ns / 1ps
interface ffba_req_if;
   logic                        valid;
   logic                        ready;
   logic                        action;
   logic [ffba_pkg::SIZE_W-1:0] alloc_size;
   logic [ffba_pkg::ADDR_W-1:0] block_addr;

   modport source (output valid, output action, output alloc_size, output block_addr,
                   input ready);
   modport sink (input valid, input action, input alloc_size, input block_addr,
                 output ready);
endinterface

// ===== sv/ffba_rsp_if.sv =====
// Response channel of the allocator: user address and status.
`timescale 1ns / 1ps
interface ffba_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [ffba_pkg::ADDR_W-1:0] user_addr;
   logic [ffba_pkg::STAT_W-1:0] status;

   modport source (output valid, output user_addr, output status, input ready);
   modport sink (input valid, input user_addr, input status, output ready);
endinterface

// ===== sv/first_fit_block_allocator_unit.sv =====
// First-fit heap block allocator with a table memory and a scan sequencer.
`timescale 1ns / 1ps
// The allocator keeps its block table in one single-port-write, registered-read
// memory and handles one request at a time. An allocate request scans the table
// in creation order, one entry per cycle, and takes the first free block that is
// large enough; when none fits it appends a new block at the heap break if the
// table has room and the new break stays within the heap limit. A free request
// scans for the matching user address and marks that block free. A scan can also
// end without a match, as for a free of an unknown address or an allocate into a
// full table. A free of the null address skips the scan and goes straight to the
// response state. The next request can be taken once the response is registered,
// while that response still waits in its output register. The table needs no
// clearing after reset; only entries below the block count are ever checked.
module first_fit_block_allocator_unit (
   input  logic                                 clock,
   input  logic                                 reset,
   ffba_req_if.sink                             req_ch,
   ffba_rsp_if.source                           rsp_ch,
   input  logic                                 csr_we,
   input  logic [ffba_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [ffba_pkg::ADDR_W-1:0]          csr_wdata
);
   import ffba_pkg::*;

   // Control state.
   state_type         state_ff, state_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [CNT_W-1:0]  scan_idx_ff, scan_idx_in;
   logic              chk_valid_ff, chk_valid_in;
   logic [IDX_W-1:0]  chk_idx_ff, chk_idx_in;
   logic [IDX_W-1:0]  hit_idx_ff, hit_idx_in;
   logic [ADDR_W-1:0] brk_ff, brk_in;
   logic [ADDR_W-1:0] limit_ff, limit_in;
   logic              rsp_valid_ff, rsp_valid_in;

   // Payload registers.
   logic              act_ff, act_in;
   logic [SIZE_W-1:0] size_ff, size_in;
   logic [ADDR_W-1:0] addr_ff, addr_in;
   entry_type         ent_ff, ent_in;
   logic [NB_W-1:0]   nb_ff, nb_in;
   logic [ADDR_W-1:0] res_user_ff, res_user_in;
   status_type        res_status_ff, res_status_in;
   logic [ADDR_W-1:0] rsp_user_ff, rsp_user_in;
   status_type        rsp_status_ff, rsp_status_in;

   // Table memory.
   entry_type         mem [MAX_BLOCKS];
   entry_type         rd_data_ff;
   logic [IDX_W-1:0]  rd_addr;
   logic              wr_en;
   logic [IDX_W-1:0]  wr_addr;
   entry_type         wr_data;

   // Datapath terms.
   logic              req_fire;
   logic              hit;
   logic              alloc_fit;
   logic [ADDR_W-1:0] rd_user;
   logic [INC_W-1:0]  inc;
   logic [NB_W-1:0]   sum;

   assign req_fire = req_ch.valid && req_ch.ready;
   assign rd_addr  = scan_idx_ff[IDX_W-1:0];

   // Match test on the entry read in the previous cycle.
   assign rd_user   = ADDR_W'(rd_data_ff.start + ADDR_W'(HEADER_BYTES));
   assign alloc_fit = rd_data_ff.free && (rd_data_ff.size >= size_ff);
   assign hit       = chk_valid_ff &&
                      ((act_ff == ACT_ALLOC) ? alloc_fit : (rd_user == addr_ff));

   // Break growth: round the raw end down to the alignment, then add one unit.
   assign inc = INC_W'(HEADER_BYTES) + INC_W'(size_ff);
   assign sum = NB_W'(brk_ff) + NB_W'(inc);

   // Memory write and registered read.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   // Sequencer next state and datapath updates.
   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      scan_idx_in   = scan_idx_ff;
      chk_valid_in  = 1'b0;
      chk_idx_in    = chk_idx_ff;
      hit_idx_in    = hit_idx_ff;
      brk_in        = brk_ff;
      limit_in      = limit_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ch.ready;
      act_in        = act_ff;
      size_in       = size_ff;
      addr_in       = addr_ff;
      ent_in        = ent_ff;
      nb_in         = nb_ff;
      res_user_in   = res_user_ff;
      res_status_in = res_status_ff;
      rsp_user_in   = rsp_user_ff;
      rsp_status_in = rsp_status_ff;
      wr_en         = 1'b0;
      wr_addr       = hit_idx_ff;
      wr_data       = ent_ff;
      req_ch.ready  = (state_ff == ST_IDLE);

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               act_in      = req_ch.action;
               size_in     = req_ch.alloc_size;
               addr_in     = req_ch.block_addr;
               scan_idx_in = '0;
               res_user_in = '0;
               if (req_ch.action == ACT_FREE && req_ch.block_addr == '0) begin
                  res_status_in = STATUS_OK;
                  state_in      = ST_RESP;
               end else begin
                  state_in = ST_SCAN;
               end
            end
         end

         ST_SCAN: begin
            if (hit) begin
               ent_in     = rd_data_ff;
               hit_idx_in = chk_idx_ff;
               state_in   = ST_HIT;
            end else if (scan_idx_ff < count_ff) begin
               // Issue the next table read; its data is checked next cycle.
               chk_valid_in = 1'b1;
               chk_idx_in   = scan_idx_ff[IDX_W-1:0];
               scan_idx_in  = scan_idx_ff + CNT_W'(1);
            end else if (!chk_valid_ff) begin
               // Scan ended without a match.
               if (act_ff == ACT_FREE) begin
                  res_status_in = STATUS_UNKNOWN;
                  state_in      = ST_RESP;
               end else if (count_ff >= CNT_W'(MAX_BLOCKS)) begin
                  res_status_in = STATUS_NOMEM;
                  state_in      = ST_RESP;
               end else begin
                  state_in = ST_GROW;
               end
            end
         end

         ST_HIT: begin
            wr_data = ent_ff;
            if (act_ff == ACT_ALLOC) begin
               wr_en         = 1'b1;
               wr_data.free  = 1'b0;
               res_user_in   = ADDR_W'(ent_ff.start + ADDR_W'(HEADER_BYTES));
               res_status_in = STATUS_OK;
            end else if (ent_ff.free) begin
               res_status_in = STATUS_DOUBLE;
            end else begin
               wr_en         = 1'b1;
               wr_data.free  = 1'b1;
               res_status_in = STATUS_OK;
            end
            state_in = ST_RESP;
         end

         ST_GROW: begin
            if (inc == '0) begin
               nb_in = NB_W'(brk_ff);
            end else begin
               nb_in = sum - (sum % NB_W'(ALIGN_BYTES)) + NB_W'(ALIGN_BYTES);
            end
            state_in = ST_COMMIT;
         end

         ST_COMMIT: begin
            if (nb_ff > NB_W'(limit_ff) || nb_ff[NB_W-1:ADDR_W] != '0) begin
               res_status_in = STATUS_NOMEM;
            end else begin
               wr_en         = 1'b1;
               wr_addr       = count_ff[IDX_W-1:0];
               wr_data.start = brk_ff;
               wr_data.size  = size_ff;
               wr_data.free  = 1'b0;
               count_in      = count_ff + CNT_W'(1);
               brk_in        = nb_ff[ADDR_W-1:0];
               res_user_in   = ADDR_W'(brk_ff + ADDR_W'(HEADER_BYTES));
               res_status_in = STATUS_OK;
            end
            state_in = ST_RESP;
         end

         ST_RESP: begin
            // Move the result into the output register once it is free.
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_user_in   = res_user_ff;
               rsp_status_in = res_status_ff;
               state_in      = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // Configuration writes must arrive only while the block is idle; the block itself does not enforce this.
      if (csr_we) begin
         unique case (csr_index)
            CSR_HEAP_BASE: begin
               if (count_ff == '0) begin
                  brk_in = csr_wdata;
               end
            end
            CSR_HEAP_LIMIT: begin
               limit_in = csr_wdata;
            end
            default: begin
               limit_in = limit_ff;
            end
         endcase
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         scan_idx_ff  <= '0;
         chk_valid_ff <= 1'b0;
         brk_ff       <= '0;
         limit_ff     <= '1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         scan_idx_ff  <= scan_idx_in;
         chk_valid_ff <= chk_valid_in;
         brk_ff       <= brk_in;
         limit_ff     <= limit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      chk_idx_ff    <= chk_idx_in;
      hit_idx_ff    <= hit_idx_in;
      act_ff        <= act_in;
      size_ff       <= size_in;
      addr_ff       <= addr_in;
      ent_ff        <= ent_in;
      nb_ff         <= nb_in;
      res_user_ff   <= res_user_in;
      res_status_ff <= res_status_in;
      rsp_user_ff   <= rsp_user_in;
      rsp_status_ff <= rsp_status_in;
   end

   // Response outputs.
   assign rsp_ch.valid     = rsp_valid_ff;
   assign rsp_ch.user_addr = rsp_user_ff;
   assign rsp_ch.status    = rsp_status_ff;

   // The block count never passes the table depth.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_BLOCKS))
      else $error("block count exceeds table depth");

   // The table is written only when a hit is resolved or a block is appended.
   a_write_state: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (state_ff == ST_HIT || state_ff == ST_COMMIT))
      else $error("table write outside update states");

   // A checked read always refers to an entry below the block count.
   a_read_bound: assert property (@(posedge clock) disable iff (reset)
      chk_valid_ff |-> (CNT_W'(chk_idx_ff) < count_ff))
      else $error("table read beyond block count");

   // An accepted request always starts work.
   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> state_ff != ST_IDLE)
      else $error("accepted request was dropped");

   // A failed or free response carries a zero user address.
   a_zero_user: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff != STATUS_OK) |-> rsp_user_ff == '0)
      else $error("nonzero user address on error response");

endmodule

// ===== bench/tb.sv =====
// Self-checking testbench for the first-fit heap block allocator.
`timescale 1ns / 1ps
module tb;
   import ffba_pkg::*;

   localparam logic [63:0] ADDR_MASK    = 64'h0000_FFFF_FFFF_FFFF;
   localparam logic [ADDR_W-1:0] ADDR_MAX = 48'hFFFF_FFFF_FFFF;
   localparam int WATCHDOG_LIMIT      = 2000;
   localparam int DRAIN_CYCLES        = 100;
   localparam int LONG_HOLD_CYCLES    = 300;
   localparam int LONG_HOLD_AFTER     = 40;
   localparam int NUM_ROWS            = 23;

   typedef enum logic {ROW_REQUEST, ROW_WRITE} row_kind_type;

   // One line of the directed table; a write row carries its data in value.
   typedef struct packed {
      row_kind_type          kind;
      logic                  action;
      logic [CSR_IDX_W-1:0]  sel;
      logic [SIZE_W-1:0]     size;
      logic [ADDR_W-1:0]     value;
      logic                  fixed;
      logic [ADDR_W-1:0]     want_addr;
      status_type            want_status;
   } step_type;

   typedef struct packed {
      logic [ADDR_W-1:0] user_addr;
      status_type        status;
   } reply_type;

   logic                 clock;
   logic                 reset;
   logic                 csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [ADDR_W-1:0]    csr_wdata;

   ffba_req_if req_ch ();
   ffba_rsp_if rsp_ch ();

   first_fit_block_allocator_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // Shadow copy of the block table, the break and the two registers.
   logic [ADDR_W-1:0] heap_start   [MAX_BLOCKS];
   logic [SIZE_W-1:0] heap_len     [MAX_BLOCKS];
   logic              heap_is_free [MAX_BLOCKS];
   int                heap_blocks;
   logic [ADDR_W-1:0] heap_break;
   logic [ADDR_W-1:0] cfg_base;
   logic [ADDR_W-1:0] cfg_limit;

   reply_type pending_replies [$];
   int        error_count;
   int        replies_seen;
   int        quiet_cycles;
   bit        gaps_on;
   bit        stalls_on;

   // Directed table: register extremes first while the table is empty, then the
   // free-path corner cases, reuse of a large block and the exact limit boundary.
   step_type script [NUM_ROWS] = '{
      '{ROW_WRITE,   ACT_ALLOC, CSR_HEAP_LIMIT, 32'd0, 48'd0, 1'b0, 48'd0, STATUS_OK},
      '{ROW_REQUEST, ACT_ALLOC, CSR_HEAP_BASE, 32'd0, 48'd0, 1'b1, 48'd0, STATUS_NOMEM},
      '{ROW_WRITE,   ACT_ALLOC, CSR_HEAP_BASE, 32'd0, ADDR_MAX, 1'b0, 48'd0, STATUS_OK},
      '{ROW_WRITE,   ACT_ALLOC, CSR_HEAP_LIMIT, 32'd0, ADDR_MAX, 1'b0, 48'd0, STATUS_OK},
      '{ROW_REQUEST, ACT_ALLOC, CSR_HEAP_BASE, 32'd0, 48'd0, 1'b1, 48'd0, STATUS_NOMEM},
      '{ROW_WRITE,   ACT_ALLOC, CSR_HEAP_BASE, 32'd0, 48'd0, 1'b0, 48'd0, STATUS_OK},
      '{ROW_REQUEST, ACT_ALLOC, CSR_HEAP_BASE, 32'd0, 48'd0, 1'b1, 48'd24, STATUS_OK},
      '{ROW_REQUEST, ACT_FREE,  CSR_HEAP_BASE, 32'd0, 48'd24, 1'b1, 48'd0, STATUS_OK},
      '{ROW_REQUEST, ACT_FREE,  CSR_HEAP_BASE, 32'd0, 48'd24, 1'b1, 48'd0, STATUS_DOUBLE},
      '{ROW_REQUEST, ACT_FREE,  CSR_HEAP_BASE, 32'd0, 48'd0, 1'b1, 48'd0, STATUS_OK},
      '{ROW_REQUEST, ACT_FREE,  CSR_HEAP_BASE, 32'd0, ADDR_MAX, 1'b1, 48'd0, STATUS_UNKNOWN},
      '{ROW_REQUEST, ACT_ALLOC, CSR_HEAP_BASE, 32'hFFFF_FFFF, 48'd0, 1'b0, 48'd0, STATUS_OK},
      '{ROW_REQUEST, ACT_FREE,  CSR_HEAP_BASE, 32'd0, 48'd88, 1'b0, 48'd0, STATUS_OK},
      '{ROW_REQUEST, ACT_ALLOC, CSR_HEAP_BASE, 32'd5, 48'd0, 1'b0, 48'd0, STATUS_OK},
      '{ROW_REQUEST, ACT_ALLOC, CSR_HEAP_BASE, 32'd0, 48'd0, 1'b0, 48'd0, STATUS_OK},
      '{ROW_WRITE,   ACT_ALLOC, CSR_HEAP_BASE, 32'd0, 48'h5555_5555_5555, 1'b0, 48'd0,
        STATUS_OK},
      '{ROW_REQUEST, ACT_ALLOC, CSR_HEAP_BASE, 32'd7, 48'd0, 1'b0, 48'd0, STATUS_OK},
      '{ROW_WRITE,   ACT_ALLOC, CSR_HEAP_LIMIT, 32'd0, 48'h1_0000_0100, 1'b0, 48'd0,
        STATUS_OK},
      '{ROW_REQUEST, ACT_ALLOC, CSR_HEAP_BASE, 32'd0, 48'd0, 1'b0, 48'd0, STATUS_OK},
      '{ROW_REQUEST, ACT_ALLOC, CSR_HEAP_BASE, 32'd0, 48'd0, 1'b1, 48'd0, STATUS_NOMEM},
      '{ROW_REQUEST, ACT_FREE,  CSR_HEAP_BASE, 32'hFFFF_FFFF, 48'h1_0000_00D8, 1'b0, 48'd0,
        STATUS_OK},
      '{ROW_WRITE,   ACT_ALLOC, CSR_HEAP_LIMIT, 32'd0, ADDR_MAX, 1'b0, 48'd0, STATUS_OK},
      '{ROW_REQUEST, ACT_ALLOC, CSR_HEAP_BASE, 32'd1, 48'd0, 1'b0, 48'd0, STATUS_OK}
   };

   // Works out the reply to one request and updates the shadow table.
   function automatic reply_type predict_reply(input logic act, input logic [SIZE_W-1:0] size,
                                               input logic [ADDR_W-1:0] addr);
      reply_type   r;
      logic [63:0] step;
      logic [63:0] grown;
      logic        found;
      int          i;
      r.user_addr = '0;
      r.status    = STATUS_OK;
      found       = 1'b0;
      if (act == ACT_ALLOC) begin
         // First fit over the blocks in creation order, without splitting.
         for (i = 0; i < heap_blocks; i++) begin
            if (!found && heap_is_free[i] && heap_len[i] >= size) begin
               found           = 1'b1;
               heap_is_free[i] = 1'b0;
               r.user_addr     = heap_start[i] + ADDR_W'(HEADER_BYTES);
            end
         end
         if (!found) begin
            if (heap_blocks >= MAX_BLOCKS) begin
               r.status = STATUS_NOMEM;
            end else begin
               step = 64'(HEADER_BYTES) + 64'(size);
               if (step == 64'd0) begin
                  grown = 64'(heap_break);
               end else begin
                  grown = 64'(heap_break) + step;
                  grown = grown - (grown % 64'(ALIGN_BYTES)) + 64'(ALIGN_BYTES);
               end
               if (grown > 64'(cfg_limit) || grown > ADDR_MASK) begin
                  r.status = STATUS_NOMEM;
               end else begin
                  heap_start[heap_blocks]   = heap_break;
                  heap_len[heap_blocks]     = size;
                  heap_is_free[heap_blocks] = 1'b0;
                  heap_blocks++;
                  r.user_addr = heap_break + ADDR_W'(HEADER_BYTES);
                  heap_break  = grown[ADDR_W-1:0];
               end
            end
         end
      end else if (addr != '0) begin
         // Free: the earliest block with a matching user address is the one used.
         for (i = 0; i < heap_blocks; i++) begin
            if (!found && heap_start[i] + ADDR_W'(HEADER_BYTES) == addr) begin
               found = 1'b1;
               if (heap_is_free[i]) begin
                  r.status = STATUS_DOUBLE;
               end else begin
                  heap_is_free[i] = 1'b1;
               end
            end
         end
         if (!found) begin
            r.status = STATUS_UNKNOWN;
         end
      end
      return r;
   endfunction

   // Lowers the request valid and keeps it low for the given number of cycles.
   task automatic idle_request(input int cycles);
      @(negedge clock);
      req_ch.valid = 1'b0;
      repeat (cycles - 1) @(negedge clock);
   endtask

   // Offers one request and queues its reply once the request is taken.
   task automatic send_request(input logic act, input logic [SIZE_W-1:0] size,
                               input logic [ADDR_W-1:0] addr, input reply_type want);
      @(negedge clock);
      req_ch.valid      = 1'b1;
      req_ch.action     = act;
      req_ch.alloc_size = size;
      req_ch.block_addr = addr;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      pending_replies.push_back(want);
      if (gaps_on && $urandom_range(0, 3) == 0) begin
         idle_request($urandom_range(1, 19));
      end
   endtask

   // Register writes happen only once the block has answered everything.
   task automatic write_register(input logic [CSR_IDX_W-1:0] sel, input logic [ADDR_W-1:0] data);
      idle_request(1);
      while (pending_replies.size() != 0) @(posedge clock);
      @(negedge clock);
      csr_we    = 1'b1;
      csr_index = sel;
      csr_wdata = data;
      @(negedge clock);
      csr_we = 1'b0;
      if (sel == CSR_HEAP_BASE) begin
         cfg_base = data;
         if (heap_blocks == 0) begin
            heap_break = data;
         end
      end else begin
         cfg_limit = data;
      end
   endtask

   // Allocations sized from existing blocks or at random, and frees mostly of
   // block addresses, with null frees and random addresses mixed in.
   task automatic issue_random_request();
      logic              act;
      logic [SIZE_W-1:0] size;
      logic [ADDR_W-1:0] addr;
      reply_type         want;
      int                pick;
      int                i;
      act  = ($urandom_range(0, 99) < 55) ? ACT_ALLOC : ACT_FREE;
      size = $urandom();
      addr = ADDR_W'({$urandom(), $urandom()});
      pick = $urandom_range(0, 99);
      i    = (heap_blocks > 0) ? $urandom_range(0, heap_blocks - 1) : 0;
      if (act == ACT_ALLOC) begin
         if (pick < 35 && heap_blocks > 0) begin
            size = heap_len[i] >> $urandom_range(0, 1);
         end else if (pick < 75) begin
            size = $urandom_range(0, 200);
         end else if (pick < 90) begin
            size = $urandom_range(0, 65535);
         end
      end else begin
         if (pick < 60 && heap_blocks > 0) begin
            addr = heap_start[i] + ADDR_W'(HEADER_BYTES);
         end else if (pick < 70) begin
            addr = '0;
         end
      end
      want = predict_reply(act, size, addr);
      send_request(act, size, addr, want);
   endtask

   // Free-running clock, 20 ns period.
   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   // Reply checker: every reply must match the oldest expectation.
   always @(posedge clock) begin
      reply_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         replies_seen++;
         if (pending_replies.size() == 0) begin
            $display("%0t: unexpected reply user_addr %h status %0d", $time,
                     rsp_ch.user_addr, rsp_ch.status);
            error_count++;
         end else begin
            want = pending_replies.pop_front();
            if (rsp_ch.user_addr !== want.user_addr) begin
               $display("%0t: user_addr expected %h, got %h", $time,
                        want.user_addr, rsp_ch.user_addr);
               error_count++;
            end
            if (rsp_ch.status !== want.status) begin
               $display("%0t: status expected %0d, got %0d", $time,
                        want.status, rsp_ch.status);
               error_count++;
            end
         end
      end
   end

   // Watchdog on cycles in which neither channel moves anything.
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("** first_fit_block_allocator_unit: FAILED **");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Reply side: random stall bursts, plus one long hold that backs up the block.
   initial begin
      int  stall_left;
      int  hold_left;
      bit  hold_done;
      stall_left   = 0;
      hold_left    = 0;
      hold_done    = 1'b0;
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (!hold_done && replies_seen >= LONG_HOLD_AFTER) begin
            hold_done = 1'b1;
            hold_left = LONG_HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ch.ready = 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_ch.ready = 1'b0;
         end else if (stalls_on && $urandom_range(0, 5) == 0) begin
            stall_left   = $urandom_range(1, 19) - 1;
            rsp_ch.ready = 1'b0;
         end else begin
            rsp_ch.ready = 1'b1;
         end
      end
   end

   // Main sequence: reset, directed table, then three random phases.
   initial begin
      reply_type   want;
      logic [63:0] roof;
      int          n;
      reset             = 1'b1;
      req_ch.valid      = 1'b0;
      req_ch.action     = ACT_ALLOC;
      req_ch.alloc_size = '0;
      req_ch.block_addr = '0;
      csr_we            = 1'b0;
      csr_index         = CSR_HEAP_BASE;
      csr_wdata         = '0;
      error_count       = 0;
      replies_seen      = 0;
      quiet_cycles      = 0;
      gaps_on           = 1'b1;
      stalls_on         = 1'b1;
      heap_blocks       = 0;
      cfg_base          = '0;
      cfg_limit         = ADDR_MAX;
      heap_break        = '0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed table; fixed rows carry their reply, the rest use the predictor.
      for (n = 0; n < NUM_ROWS; n++) begin
         if (script[n].kind == ROW_WRITE) begin
            write_register(script[n].sel, script[n].value);
         end else begin
            want = predict_reply(script[n].action, script[n].size, script[n].value);
            if (script[n].fixed) begin
               want.user_addr = script[n].want_addr;
               want.status    = script[n].want_status;
            end
            send_request(script[n].action, script[n].size, script[n].value, want);
         end
      end

      // Open heap, idling on both sides.
      for (n = 0; n < 200; n++) begin
         issue_random_request();
      end

      // Tight heap limit just above the break, so growth fails often.
      roof = 64'(heap_break) + 64'($urandom_range(0, 8192));
      if (roof > ADDR_MASK) begin
         roof = ADDR_MASK;
      end
      write_register(CSR_HEAP_LIMIT, roof[ADDR_W-1:0]);
      write_register(CSR_HEAP_BASE, ADDR_W'({$urandom(), $urandom()}));
      for (n = 0; n < 150; n++) begin
         issue_random_request();
      end

      // Open heap again, back to back with no idling.
      write_register(CSR_HEAP_LIMIT, ADDR_MAX);
      gaps_on   = 1'b0;
      stalls_on = 1'b0;
      for (n = 0; n < 230; n++) begin
         issue_random_request();
      end

      idle_request(1);
      while (pending_replies.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("** first_fit_block_allocator_unit: PASSED **");
      end else begin
         $display("** first_fit_block_allocator_unit: FAILED **");
      end
      $finish;
   end

endmodule
